// ===== hw/rtl/dlr_pkg.sv =====
// Shared types, constants and command codes of the LED display RAM refresh block.
package dlr_pkg;

    // Default size of the shadow display RAM in bytes (1 to 16)
    localparam int DISPLAY_BYTES_DEF = 14;
    // RAM address width covering the largest supported RAM
    localparam int RAM_ADDR_W = 4;

    // Command codes
    localparam logic [2:0] CMD_SET_SEG   = 3'd0;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd1;
    localparam logic [2:0] CMD_FILL_ALL  = 3'd2;
    localparam logic [2:0] CMD_AUTO_REF  = 3'd3;
    localparam logic [2:0] CMD_FIXED_REF = 3'd4;
    localparam logic [2:0] CMD_DIRECT    = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE       = 3'd0;
    localparam logic [2:0] CFG_AUTO_DATA  = 3'd1;
    localparam logic [2:0] CFG_FIXED_DATA = 3'd2;
    localparam logic [2:0] CFG_ADDR_BASE  = 3'd3;
    localparam logic [2:0] CFG_DISP_CTRL  = 3'd4;

    // Configuration reset values
    localparam logic [7:0] MODE_RST       = 8'd3;
    localparam logic [7:0] AUTO_DATA_RST  = 8'd64;
    localparam logic [7:0] FIXED_DATA_RST = 8'd68;
    localparam logic [7:0] ADDR_BASE_RST  = 8'd192;
    localparam logic [7:0] DISP_CTRL_RST  = 8'd143;

    // RAM contents after clear all and fill all
    localparam logic [7:0] CLEAR_BYTE = 8'h00;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;

    // One host command
    typedef struct packed {
        logic [2:0] command;
        logic [3:0] seg_address;
        logic [3:0] bit_index;
        logic       turn_on;
        logic [3:0] start_address;
        logic [7:0] direct_byte;
    } item_t;

    // One link byte
    typedef struct packed {
        logic [7:0] link_byte;
        logic       strobe_before;
        logic       last_byte;
    } result_t;

    // Configuration register file
    typedef struct packed {
        logic [7:0] mode_command;
        logic [7:0] auto_data_command;
        logic [7:0] fixed_data_command;
        logic [7:0] address_command_base;
        logic [7:0] display_control;
    } cfg_t;

    // Access request from the sequencer to the display RAM
    typedef struct packed {
        logic                  rd_en;
        logic [RAM_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [RAM_ADDR_W-1:0] wr_addr;
        logic [7:0]            wr_data;
        logic                  clr_en;
        logic [7:0]            clr_value;
    } ram_req_t;

endpackage

// ===== hw/rtl/dlr_ram.sv =====
// Shadow display RAM: synchronous memory with per-entry valid bits and a bulk fill value.
module dlr_ram #(
    parameter int DISPLAY_BYTES = dlr_pkg::DISPLAY_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dlr_pkg::ram_req_t req,
    output logic [7:0]        rdata
);

    localparam int AW = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1;

    logic [7:0]               mem [DISPLAY_BYTES];
    logic [DISPLAY_BYTES-1:0] valid_reg;
    logic [7:0]               fill_reg;
    logic [7:0]               rdata_reg;

    // Track written entries; a bulk clear or fill drops all of them at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= dlr_pkg::CLEAR_BYTE;
        end
        else if (req.clr_en)
        begin
            valid_reg <= '0;
            fill_reg  <= req.clr_value;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr[AW-1:0]] <= 1'b1;
        end
    end

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= valid_reg[req.rd_addr[AW-1:0]] ? mem[req.rd_addr[AW-1:0]]
                                                         : fill_reg;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dlr_ctrl.sv =====
// Command sequencer: segment read-modify-write, bulk clear/fill and link byte bursts.
module dlr_ctrl #(
    parameter int DISPLAY_BYTES = dlr_pkg::DISPLAY_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dlr_pkg::item_t    item,
    input  dlr_pkg::cfg_t     cfg,
    input  logic [7:0]        rdata,
    output dlr_pkg::ram_req_t req,
    output logic              busy,
    output dlr_pkg::result_t  result,
    output logic              result_strobe
);

    localparam int AW = dlr_pkg::RAM_ADDR_W;
    localparam logic [AW:0]   NUM_BYTES = (AW+1)'(DISPLAY_BYTES);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DISPLAY_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEG_WR,
        S_MODE,
        S_DCMD,
        S_ADDR,
        S_DATA,
        S_DIRECT,
        S_CTRL
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [3:0]       start_reg, start_next;
    logic [7:0]       dbyte_reg, dbyte_next;
    logic [2:0]       bit_reg, bit_next;
    logic             on_reg, on_next;
    dlr_pkg::result_t result_reg, result_next;
    logic             strobe_reg, strobe_next;

    logic [AW:0]      seg_target;
    logic [4:0]       fixed_addr;
    logic [7:0]       seg_mask;

    assign seg_target = {1'b0, item.seg_address} + (AW+1)'(item.bit_index[3]);
    assign fixed_addr = {1'b0, start_reg} + {1'b0, idx_reg};
    assign seg_mask   = 8'd1 << bit_reg;

    // Next state, RAM requests and the next link byte
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        dbyte_next  = dbyte_reg;
        bit_next    = bit_reg;
        on_next     = on_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = item.command;
                    idx_next   = '0;
                    start_next = item.start_address;
                    dbyte_next = item.direct_byte;
                    bit_next   = item.bit_index[2:0];
                    on_next    = item.turn_on;
                    case (item.command)
                        dlr_pkg::CMD_SET_SEG:
                        begin
                            // Read the target byte; drop writes past the end of RAM
                            if (seg_target < NUM_BYTES)
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = seg_target[AW-1:0];
                                idx_next    = seg_target[AW-1:0];
                                state_next  = S_SEG_WR;
                            end
                        end
                        dlr_pkg::CMD_CLEAR_ALL:
                        begin
                            req.clr_en    = 1'b1;
                            req.clr_value = dlr_pkg::CLEAR_BYTE;
                        end
                        dlr_pkg::CMD_FILL_ALL:
                        begin
                            req.clr_en    = 1'b1;
                            req.clr_value = dlr_pkg::FILL_BYTE;
                        end
                        dlr_pkg::CMD_AUTO_REF, dlr_pkg::CMD_FIXED_REF, dlr_pkg::CMD_DIRECT:
                        begin
                            state_next = S_MODE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEG_WR:
            begin
                // Modify the byte just read and write it back
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg;
                req.wr_data = on_reg ? (rdata | seg_mask) : (rdata & ~seg_mask);
                state_next  = S_IDLE;
            end
            S_MODE:
            begin
                result_next = '{cfg.mode_command, 1'b1, 1'b0};
                strobe_next = 1'b1;
                state_next  = S_DCMD;
            end
            S_DCMD:
            begin
                result_next = '{(cmd_reg == dlr_pkg::CMD_AUTO_REF) ? cfg.auto_data_command
                                                                   : cfg.fixed_data_command,
                                1'b1, 1'b0};
                strobe_next = 1'b1;
                state_next  = S_ADDR;
            end
            S_ADDR:
            begin
                strobe_next = 1'b1;
                case (cmd_reg)
                    dlr_pkg::CMD_AUTO_REF:
                    begin
                        result_next = '{cfg.address_command_base, 1'b1, 1'b0};
                        req.rd_en   = 1'b1;
                        req.rd_addr = '0;
                        state_next  = S_DATA;
                    end
                    dlr_pkg::CMD_FIXED_REF:
                    begin
                        result_next = '{cfg.address_command_base | {3'b000, fixed_addr},
                                        1'b1, 1'b0};
                        req.rd_en   = 1'b1;
                        req.rd_addr = idx_reg;
                        state_next  = S_DATA;
                    end
                    default:
                    begin
                        result_next = '{cfg.address_command_base | {4'b0000, start_reg},
                                        1'b1, 1'b0};
                        state_next  = S_DIRECT;
                    end
                endcase
            end
            S_DATA:
            begin
                // Emit the byte read last cycle; prefetch the next one in auto mode
                result_next = '{rdata, 1'b0, 1'b0};
                strobe_next = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_CTRL;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    if (cmd_reg == dlr_pkg::CMD_AUTO_REF)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = idx_reg + AW'(1);
                    end
                    else
                    begin
                        state_next = S_ADDR;
                    end
                end
            end
            S_DIRECT:
            begin
                result_next = '{dbyte_reg, 1'b0, 1'b0};
                strobe_next = 1'b1;
                state_next  = S_CTRL;
            end
            S_CTRL:
            begin
                result_next = '{cfg.display_control, 1'b1, 1'b1};
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, item fields and the registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= dlr_pkg::CMD_SET_SEG;
            idx_reg    <= '0;
            start_reg  <= '0;
            dbyte_reg  <= '0;
            bit_reg    <= '0;
            on_reg     <= 1'b0;
            result_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            idx_reg    <= idx_next;
            start_reg  <= start_next;
            dbyte_reg  <= dbyte_next;
            bit_reg    <= bit_next;
            on_reg     <= on_next;
            result_reg <= result_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

// ===== hw/rtl/led_display_ram_serial_refresh.sv =====
// Top level of the LED display RAM block with serial refresh bursts.
//
// Channel   Direction  Transfer condition          Payload
// item      in         start && !busy at clk edge  dlr_pkg::item_t
// result    out        result_strobe (one cycle)   dlr_pkg::result_t
// config    in         cfg_we at clk edge          cfg_index, cfg_data
//
// Steps: set segment reads the RAM byte, then writes it back; clear all and fill
// all act while idle (valid bits dropped, fill value latched). Auto refresh sends
// mode, data command, address, each RAM byte and control; fixed refresh sends an
// address before each byte; direct sends one byte. busy is high while work remains;
// the final byte of a burst shows in the cycle busy falls.
// Reset: rst_n asynchronous, RAM reads as zero at once, no clearing pass.
// The receiver cannot stall: each result is valid for one cycle only.
module led_display_ram_serial_refresh #(
    parameter int DISPLAY_BYTES = dlr_pkg::DISPLAY_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  dlr_pkg::item_t   item,
    output logic             busy,
    output dlr_pkg::result_t result,
    output logic             result_strobe,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

    dlr_pkg::cfg_t     cfg_reg;
    dlr_pkg::ram_req_t ram_req;
    logic [7:0]        ram_rdata;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_command         <= dlr_pkg::MODE_RST;
            cfg_reg.auto_data_command    <= dlr_pkg::AUTO_DATA_RST;
            cfg_reg.fixed_data_command   <= dlr_pkg::FIXED_DATA_RST;
            cfg_reg.address_command_base <= dlr_pkg::ADDR_BASE_RST;
            cfg_reg.display_control      <= dlr_pkg::DISP_CTRL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dlr_pkg::CFG_MODE:       cfg_reg.mode_command         <= cfg_data;
                dlr_pkg::CFG_AUTO_DATA:  cfg_reg.auto_data_command    <= cfg_data;
                dlr_pkg::CFG_FIXED_DATA: cfg_reg.fixed_data_command   <= cfg_data;
                dlr_pkg::CFG_ADDR_BASE:  cfg_reg.address_command_base <= cfg_data;
                dlr_pkg::CFG_DISP_CTRL:  cfg_reg.display_control      <= cfg_data;
                default:                 cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    dlr_ctrl #(
        .DISPLAY_BYTES(DISPLAY_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .cfg          (cfg_reg),
        .rdata        (ram_rdata),
        .req          (ram_req),
        .busy         (busy),
        .result       (result),
        .result_strobe(result_strobe)
    );

    dlr_ram #(
        .DISPLAY_BYTES(DISPLAY_BYTES)
    ) u_ram (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (ram_req),
        .rdata(ram_rdata)
    );

    // A burst ends with one marked byte and nothing right behind it
    a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last_byte |=> !result_strobe)
        else $error("result strobe right after final byte");

    // A byte seen while idle can only be the final byte of a burst
    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !busy |-> result.last_byte)
        else $error("non-final byte while not busy");

    // The sequencer leaves idle only on a command transfer
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

endmodule
